// ----- sv/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhpq_pkg: shared definitions for the binary heap priority queue
// Sizes, operation and status codes, sequencer states and the key compare.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // byte address bit that selects the register word
  localparam int REG_SEL_BIT = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic MODE_MIN = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_RM_ROOT,
    ST_RM_LAST,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R
  } state_e;

  // True when key a must sit strictly above key b in the selected order.
  function automatic logic ranks_above(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                       logic mode);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    return (mode == MODE_MIN) ? lt : gt;
  endfunction

endpackage

// ----- sv/bhpq_ram.sv -----
// ----------------------------------------------------------------------------
// bhpq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/binary_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: min/max heap of signed 32-bit keys
// Array heap in one RAM, walked by a small sequencer with one key compare function.
// ----------------------------------------------------------------------------
// Usage:
//   Command: pulse start with func_i/value_i while busy is low; the beat is
//   taken at that edge and busy rises the next cycle until the result goes out.
//   func_i = insert pushes value_i, func_i = remove pops the root.
//   Result: done_o is high for exactly one cycle with status_o/item_o
//   (ok / full / empty; item_o is the popped key, zero otherwise). The
//   receiver cannot stall, so the result is taken in that cycle.
//   A refused op is answered in the cycle after it is taken. An insert climbs
//   level by level, paced by the single RAM read port: read the parent, then
//   compare and write; a remove walks down with two child reads and one write
//   per level. One command is in flight at a time.
//   Config: APB register 0 (byte 0) holds heap_mode, 0 = min-heap,
//   1 = max-heap. Write it only while busy is low. Stored keys are not
//   reordered on a mode change.
//   Reset: fill count and heap_mode clear to zero; RAM contents are don't-care
//   since only entries below the fill count are ever read.
module binary_heap_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [bhpq_pkg::DATA_W-1:0]   value_i,
  // result channel
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [bhpq_pkg::DATA_W-1:0]   item_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhpq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import bhpq_pkg::*;

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic mode_q;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[REG_SEL_BIT] == 1'b0);
  assign prdata  = reg_hit ? {31'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MIN;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode_q <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic [DATA_W-1:0]   key_q, key_d;      // key being sifted (the "hole" value)
  logic [DATA_W-1:0]   item_q, item_d;
  logic [DATA_W-1:0]   bval_q, bval_d;    // best of key and left child
  logic                lbest_q, lbest_d;  // left child beat the key
  status_e             status_q, status_d;
  logic                done_q, done_d;

  // RAM port signals
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  // index arithmetic; child indices carry extra bits to compare with fill
  logic [ADDR_W-1:0]   pos_m1;
  logic [ADDR_W-1:0]   parent;
  logic [ADDR_W+1:0]   left_idx;
  logic [ADDR_W+1:0]   right_idx;
  logic [ADDR_W+1:0]   fill_ext;
  logic                left_in;
  logic                right_in;
  logic                win;

  assign pos_m1    = pos_q - ADDR_W'(1);
  assign parent    = {1'b0, pos_m1[ADDR_W-1:1]};
  assign left_idx  = {1'b0, pos_q, 1'b1};
  assign right_idx = left_idx + (ADDR_W+2)'(1);
  assign fill_ext  = (ADDR_W+2)'(fill_q);
  assign left_in   = left_idx < fill_ext;
  assign right_in  = right_idx < fill_ext;

  bhpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    item_q   <= item_d;
    bval_q   <= bval_d;
    lbest_q  <= lbest_d;
    status_q <= status_d;
  end

  // --------------------------------------------------------------------------
  // Next state. Sifts move a hole instead of swapping: the walked-over entry
  // drops into the hole, and the key lands once where the walk stops.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    key_d     = key_q;
    item_d    = item_q;
    bval_d    = bval_q;
    lbest_d   = lbest_q;
    status_d  = status_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = key_q;
    mem_raddr = '0;
    win       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // no new command during the result cycle
        if (start && !busy) begin
          item_d   = '0;
          status_d = STATUS_OK;
          if (func_i == FUNC_INSERT) begin
            if (fill_q == CNT_W'(CAPACITY)) begin
              status_d = STATUS_FULL;
              done_d   = 1'b1;
            end else begin
              key_d   = value_i;
              pos_d   = fill_q[ADDR_W-1:0];
              fill_d  = fill_q + CNT_W'(1);
              state_d = ST_UP_CHK;
            end
          end else begin
            if (fill_q == '0) begin
              status_d = STATUS_EMPTY;
              done_d   = 1'b1;
            end else begin
              mem_raddr = '0;
              fill_d    = fill_q - CNT_W'(1);
              state_d   = ST_RM_ROOT;
            end
          end
        end
      end

      ST_UP_CHK: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mem_raddr = parent;
          state_d   = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (ranks_above(key_q, mem_rdata, mode_q)) begin
          mem_wdata = mem_rdata;
          pos_d     = parent;
          state_d   = ST_UP_CHK;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_RM_ROOT: begin
        item_d    = mem_rdata;
        mem_raddr = fill_q[ADDR_W-1:0];  // old last entry
        state_d   = ST_RM_LAST;
      end

      ST_RM_LAST: begin
        key_d   = mem_rdata;
        pos_d   = '0;
        state_d = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (!left_in) begin
          mem_we  = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mem_raddr = left_idx[ADDR_W-1:0];
          state_d   = ST_DN_L;
        end
      end

      ST_DN_L: begin
        win = ranks_above(mem_rdata, key_q, mode_q);
        if (right_in) begin
          lbest_d   = win;
          bval_d    = win ? mem_rdata : key_q;
          mem_raddr = right_idx[ADDR_W-1:0];
          state_d   = ST_DN_R;
        end else begin
          mem_we = 1'b1;
          if (win) begin
            mem_wdata = mem_rdata;
            pos_d     = left_idx[ADDR_W-1:0];
            state_d   = ST_DN_CHK;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_DN_R: begin
        // left wins ties: right must rank strictly above the current best
        win    = ranks_above(mem_rdata, bval_q, mode_q);
        mem_we = 1'b1;
        if (win) begin
          mem_wdata = mem_rdata;
          pos_d     = right_idx[ADDR_W-1:0];
          state_d   = ST_DN_CHK;
        end else if (lbest_q) begin
          mem_wdata = bval_q;
          pos_d     = left_idx[ADDR_W-1:0];
          state_d   = ST_DN_CHK;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // busy covers the result cycle so a new command waits for the beat to go out
  assign busy     = (state_q != ST_IDLE) || done_q;
  assign done_o   = done_q;
  assign status_o = status_q;
  assign item_o   = item_q;

endmodule

// ----- tb/sv/binary_heap_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_test: self-checking bench for the heap queue
// Drives insert/remove commands and APB mode writes. A scoreboard class keeps
// its own heap and checks every result beat field by field.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_test;
  import bhpq_pkg::*;

  localparam logic MODE_MAX = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_HEAP_MODE = '0;

  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 112;
  localparam int MAX_GAP        = 11;
  // worst case between beats is a full-depth remove plus a MAX_GAP sender gap;
  // config writes also add quiet cycles
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] item;
  } heap_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow heap plus the queue of results still owed by the block
  // --------------------------------------------------------------------------
  class heap_tracker;
    logic [DATA_W-1:0] keys [CAPACITY];
    int unsigned       fill;
    logic              heap_mode;
    heap_result_t      owed[$];
    int unsigned       errors;

    function new();
      fill      = 0;
      heap_mode = MODE_MIN;
      errors    = 0;
    endfunction

    // a belongs strictly above b under the current order
    function bit outranks(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      if (heap_mode == MODE_MIN) return $signed(a) < $signed(b);
      return $signed(a) > $signed(b);
    endfunction

    function void swap_keys(int unsigned i, int unsigned j);
      logic [DATA_W-1:0] t;
      t = keys[i];
      keys[i] = keys[j];
      keys[j] = t;
    endfunction

    // update the shadow heap for one accepted command and queue its result
    function void note_command(logic f, logic [DATA_W-1:0] v);
      heap_result_t r;
      int unsigned pos, parent, left, right, best;
      r.status = STATUS_OK;
      r.item   = '0;
      if (f == FUNC_INSERT) begin
        if (fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          keys[fill] = v;
          pos = fill;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!outranks(keys[pos], keys[parent])) break;
            swap_keys(pos, parent);
            pos = parent;
          end
          fill++;
        end
      end else if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.item  = keys[0];
        keys[0] = keys[fill - 1];
        fill--;
        pos = 0;
        forever begin
          left  = 2 * pos + 1;
          right = left + 1;
          best  = pos;
          // strict compares: left child wins ties, equal keys stay put
          if (left < fill && outranks(keys[left], keys[best])) best = left;
          if (right < fill && outranks(keys[right], keys[best])) best = right;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [DATA_W-1:0] it);
      heap_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing owed, status %0d item %h", $time, st, it);
        return;
      end
      want = owed.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
      end
      if (it !== want.item) begin
        errors++;
        $display("%0t: item mismatch, expected %h, actual %h", $time, want.item, it);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               func_i;
  logic [DATA_W-1:0]  value_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [DATA_W-1:0]  item_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  heap_tracker tracker;
  int unsigned quiet_cycles;

  binary_heap_priority_queue uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .func_i   (func_i),
    .value_i  (value_i),
    .done_o   (done_o),
    .status_o (status_o),
    .item_o   (item_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge, so every value seen is the one held
  // during the cycle that edge closes. The result beat is checked before the
  // command beat is noted; a result can never belong to a command taken at
  // the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(status_o, item_o);
      if (start && !busy) tracker.note_command(func_i, value_i);
      if (done_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One command beat. The sender idles for gap cycles first; with no gap,
  // start simply stays high into the next command.
  task automatic issue(input logic f, input logic [DATA_W-1:0] v, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    func_i  <= f;
    value_i <= v;
    do @(posedge clk_i); while (busy);
  endtask

  // Setup cycle then access cycle; returns with psel low again.
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mode change: only once every owed result is back and busy is low.
  // Stored keys are left as they are, so later sifts use the new order.
  task automatic set_heap_mode(input logic m);
    logic [31:0] rd;
    start <= 1'b0;
    // step past the current edge first so the last command beat is already noted
    do @(posedge clk_i); while (tracker.owed.size() != 0 || busy);
    apb_access(1'b1, ADDR_HEAP_MODE, {31'b0, m}, rd);
    tracker.heap_mode = m;
    @(posedge clk_i);
    apb_access(1'b0, ADDR_HEAP_MODE, '0, rd);
    if (rd[0] !== m) begin
      tracker.errors++;
      $display("%0t: heap_mode readback, expected %0d, actual %0d", $time, m, rd[0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned insert_pct;
    int unsigned gap;
    bit          no_gaps;
    logic        m;
    logic [DATA_W-1:0] key;

    tracker      = new();
    quiet_cycles = 0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    func_i  = FUNC_INSERT;
    value_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: min-heap from reset ----
    issue(FUNC_REMOVE, $urandom, $urandom_range(0, MAX_GAP));   // remove when empty
    issue(FUNC_INSERT, 32'h7fff_ffff, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'h8000_0000, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'h0000_0000, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'hffff_ffff, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'd5, $urandom_range(0, MAX_GAP));        // equal keys
    issue(FUNC_INSERT, 32'd5, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'h8000_0000, $urandom_range(0, MAX_GAP));
    repeat (7) issue(FUNC_REMOVE, $urandom, $urandom_range(0, MAX_GAP));
    issue(FUNC_REMOVE, $urandom, 0);                              // empty again

    // ---- directed: max-heap, then flip back to min with keys still held ----
    set_heap_mode(MODE_MAX);
    issue(FUNC_INSERT, 32'd3, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'h8000_0000, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'h7fff_ffff, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, 32'd3, $urandom_range(0, MAX_GAP));
    issue(FUNC_INSERT, -32'sd7, $urandom_range(0, MAX_GAP));
    issue(FUNC_REMOVE, $urandom, $urandom_range(0, MAX_GAP));
    set_heap_mode(MODE_MIN);
    repeat (4) issue(FUNC_REMOVE, $urandom, $urandom_range(0, MAX_GAP));

    // ---- random phases: fill past capacity, drain past empty, mixed ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p % 3 == 2) m = $urandom_range(0, 1);
      else m = p[0] ? MODE_MIN : MODE_MAX;
      set_heap_mode(m);
      case (p % 3)
        0:       insert_pct = 85;   // runs into full refusals
        1:       insert_pct = 20;   // runs into empty refusals
        default: insert_pct = 50;
      endcase
      no_gaps = (p % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mix of extremes, a narrow band that forces ties, and full range
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0:       key = 32'h8000_0000;
              1:       key = 32'h7fff_ffff;
              2:       key = 32'h0000_0000;
              default: key = 32'hffff_ffff;
            endcase
          end
          1, 2, 3: key = $urandom_range(0, 8) - 4;
          default: key = $urandom;
        endcase
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        issue(($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE, key, gap);
      end
    end

    // ---- drain: wait for every owed result, then a short tail ----
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.owed.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
